// ----- hw/rtl/power_budget_reallocator_top_assert.svh -----
// Assertion macros used by the power budget reallocator's controller.
`ifndef POWER_BUDGET_REALLOCATOR_TOP_ASSERT_SVH
`define POWER_BUDGET_REALLOCATOR_TOP_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define PBR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define PBR_ASSERT(lbl, prop, msg) \
  `PBR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/pbr_pkg.sv -----
package pbr_pkg;

  localparam int WATT_W = 40;
  localparam int REC_W  = 32;
  localparam int ID_W   = 16;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_INC  = 2'd1;
  localparam logic [1:0] CMD_RED  = 2'd2;

  localparam logic [1:0] MODE_OTHER    = 2'd0;
  localparam logic [1:0] MODE_DEFAULT  = 2'd1;
  localparam logic [1:0] MODE_GREEDY   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic CFG_TOTAL_BUDGET = 1'b0;
  localparam logic CFG_SLOTS_IN_USE = 1'b1;

  typedef logic [WATT_W-1:0] watt_t;

  typedef enum logic [3:0] {
    DOP_NONE,
    DOP_LOAD_SLOT,
    DOP_STORE_REC,
    DOP_START,
    DOP_READ,
    DOP_EVAL,
    DOP_APPLY,
    DOP_FREEP,
    DOP_DEF_OK,
    DOP_PEND_DEF,
    DOP_PEND_G,
    DOP_FINISH,
    DOP_OUT_LOAD
  } pbr_op_e;

  typedef enum logic [2:0] {
    PK_SUM,
    PK_DEF,
    PK_TFR,
    PK_TEX,
    PK_GRANT
  } pbr_pass_e;

  typedef struct packed {
    pbr_op_e   op;
    pbr_pass_e kind;
    logic      src_pend2;
    logic      wx;
  } pbr_cmd_t;

  typedef struct packed {
    logic loop_go;
    logic freep_nz;
    logic freep_ge_def;
    logic pend_nz;
    logic tfree_nz;
    logic n_def;
    logic n_noex;
    logic n_ex;
    logic req_noex_nz;
    logic req_ex_nz;
  } pbr_stat_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [REC_W-1:0] cap;
    logic [REC_W-1:0] rq;
    logic [REC_W-1:0] fr;
    logic [REC_W-1:0] ex;
    logic [1:0]       mode;
  } pbr_rec_t;

  function automatic watt_t wmin(watt_t a, watt_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic watt_t wsub(watt_t a, watt_t b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

// ----- hw/rtl/power_budget_reallocator_top.sv -----
// Slot loads and ordinary records are taken while idle; the block stays ready for more.
// A record marked last starts a round: a summing pass, then up to eight more record passes,
// each reading, evaluating and applying stored records in turn via the single-port store.
// Results then leave at one per cycle unless stalled, one per slot in use, tlast on the last.
// Reset is asynchronous and active low; it clears both registers and the record count.
// No item is taken from the end of a round until its last result has been accepted.
module power_budget_reallocator_top
  import pbr_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [39:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // slot, node_id, current_cap, requested_power, freeable, extra, mode
  input  logic [151:0]  s_axis_tdata,
  // action
  input  logic          s_axis_tuser,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_slot, out_id, command, amount
  output logic [63:0]   m_axis_tdata,
  output logic          m_axis_tlast
);

  localparam int CW = $clog2(MAX_NODES + 1);

  pbr_cmd_t          cmd;
  pbr_stat_t         stat;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     cnt;
  logic [4:0]        nslots;
  logic [4:0]        out_idx;
  logic [3:0]        out_slot;
  logic [ID_W-1:0]   out_id;
  logic [1:0]        command;
  logic [WATT_W-1:0] amount;

  pbr_ctrl #(
    .MAX_NODES(MAX_NODES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tlast_o  (m_axis_tlast),
    .stat_i     (stat),
    .cnt_i      (cnt),
    .nslots_i   (nslots),
    .cmd_o      (cmd),
    .idx_o      (idx),
    .out_idx_o  (out_idx)
  );

  pbr_datapath #(
    .MAX_NODES(MAX_NODES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .slot_i            (s_axis_tdata[3:0]),
    .node_id_i         (s_axis_tdata[19:4]),
    .current_cap_i     (s_axis_tdata[51:20]),
    .requested_power_i (s_axis_tdata[83:52]),
    .spare_pwr_i       (s_axis_tdata[115:84]),
    .bonus_pwr_i       (s_axis_tdata[147:116]),
    .mode_i            (s_axis_tdata[149:148]),
    .cmd_i             (cmd),
    .idx_i             (idx),
    .out_idx_i         (out_idx),
    .stat_o            (stat),
    .cnt_o             (cnt),
    .nslots_o          (nslots),
    .out_slot_o        (out_slot),
    .out_id_o          (out_id),
    .command_o         (command),
    .amount_o          (amount)
  );

  assign m_axis_tdata = {2'b00, amount, command, out_id, out_slot};

endmodule

// ----- hw/rtl/pbr_datapath.sv -----
module pbr_datapath
  import pbr_pkg::*;
#(
  parameter int MAX_NODES = 16,
  localparam int SLOTS = (MAX_NODES < 16) ? MAX_NODES : 16,
  localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int CW    = $clog2(MAX_NODES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [WATT_W-1:0] cfg_wdata_i,
  input  logic [3:0]        slot_i,
  input  logic [ID_W-1:0]   node_id_i,
  input  logic [REC_W-1:0]  current_cap_i,
  input  logic [REC_W-1:0]  requested_power_i,
  input  logic [REC_W-1:0]  spare_pwr_i,
  input  logic [REC_W-1:0]  bonus_pwr_i,
  input  logic [1:0]        mode_i,
  input  pbr_cmd_t          cmd_i,
  input  logic [CW-1:0]     idx_i,
  input  logic [4:0]        out_idx_i,
  output pbr_stat_t         stat_o,
  output logic [CW-1:0]     cnt_o,
  output logic [4:0]        nslots_o,
  output logic [3:0]        out_slot_o,
  output logic [ID_W-1:0]   out_id_o,
  output logic [1:0]        command_o,
  output logic [WATT_W-1:0] amount_o
);

  logic [WATT_W-1:0] total_q;
  logic [4:0]        slots_in_use_q;
  logic [4:0]        nslots_q;
  logic [CW-1:0]     cnt_q;
  logic [SLOTS-1:0]  vld_q;

  logic [ID_W-1:0]   slot_ids [SLOTS];
  logic [1:0]        cmd_tab  [SLOTS];
  watt_t             amt_tab  [SLOTS];
  pbr_rec_t          rec_mem  [MAX_NODES];
  pbr_rec_t          rd_q;

  watt_t freep_q, pend_q, pend2_q, tfree_q, caps_q;
  watt_t req_def_q, req_noex_q, req_ex_q;
  logic  n_def_q, n_noex_q, n_ex_q;
  logic  en_q;
  logic [SIW-1:0] p_q;
  watt_t t_q;

  logic           hit;
  logic [SIW-1:0] pos;
  logic           cond;
  watt_t          t_d;
  watt_t          src;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  pbr_rec_t       mem_wd;
  pbr_rec_t       wb;
  logic [SIW-1:0] ra;
  watt_t          cur_amt;
  logic [1:0]     cur_cmd;
  logic           store_ok;

  assign src      = cmd_i.src_pend2 ? pend2_q : freep_q;
  assign store_ok = (cnt_q < CW'(MAX_NODES));

  // First slot in use that holds the record's id.
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if ((5'(k) < nslots_q) && (slot_ids[k] == rd_q.id)) begin
        hit = 1'b1;
        pos = SIW'(k);
      end
    end
  end

  always_comb begin
    cond = 1'b0;
    t_d  = '0;
    case (cmd_i.kind)
      PK_DEF: begin
        cond = (rd_q.mode == MODE_DEFAULT);
        t_d  = WATT_W'(rd_q.rq);
      end
      PK_TFR: begin
        cond = (rd_q.fr != '0);
        t_d  = wmin(pend_q, WATT_W'(rd_q.fr));
      end
      PK_TEX: begin
        cond = (rd_q.ex != '0);
        t_d  = wmin(pend_q, WATT_W'(rd_q.ex));
      end
      PK_GRANT: begin
        cond = (rd_q.mode == MODE_GREEDY) && ((rd_q.ex != '0) == cmd_i.wx);
        t_d  = wmin(src, WATT_W'(rd_q.rq));
      end
      default: begin
        cond = 1'b0;
        t_d  = '0;
      end
    endcase
  end

  always_comb begin
    wb = rd_q;
    case (cmd_i.kind)
      PK_TFR:   wb.fr = rd_q.fr - t_q[REC_W-1:0];
      PK_TEX:   wb.ex = rd_q.ex - t_q[REC_W-1:0];
      PK_GRANT: wb.rq = rd_q.rq - t_q[REC_W-1:0];
      default:  wb = rd_q;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q[AW-1:0];
    mem_wd = '{id: node_id_i, cap: current_cap_i, rq: requested_power_i,
               fr: spare_pwr_i, ex: bonus_pwr_i, mode: mode_i};
    if (cmd_i.op == DOP_STORE_REC) begin
      mem_we = store_ok;
    end else if ((cmd_i.op == DOP_APPLY) && en_q && (cmd_i.kind != PK_DEF) &&
                 (cmd_i.kind != PK_SUM)) begin
      mem_we = 1'b1;
      mem_wa = idx_i[AW-1:0];
      mem_wd = wb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.op == DOP_READ) begin
      rd_q <= rec_mem[idx_i[AW-1:0]];
    end
  end

  assign ra      = (cmd_i.op == DOP_OUT_LOAD) ? out_idx_i[SIW-1:0] : p_q;
  assign cur_amt = vld_q[ra] ? amt_tab[ra] : '0;
  assign cur_cmd = vld_q[ra] ? cmd_tab[ra] : CMD_NONE;

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == DOP_LOAD_SLOT) && ({1'b0, slot_i} < 5'(SLOTS))) begin
      slot_ids[slot_i[SIW-1:0]] <= node_id_i;
    end
    if ((cmd_i.op == DOP_APPLY) && en_q && (cmd_i.kind != PK_SUM)) begin
      amt_tab[p_q] <= cur_amt + t_q;
      cmd_tab[p_q] <= ((cmd_i.kind == PK_DEF) || (cmd_i.kind == PK_GRANT)) ?
                      CMD_INC : CMD_RED;
    end
    if (cmd_i.op == DOP_OUT_LOAD) begin
      out_slot_o <= out_idx_i[3:0];
      out_id_o   <= slot_ids[out_idx_i[SIW-1:0]];
      command_o  <= cur_cmd;
      amount_o   <= cur_amt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q        <= '0;
      slots_in_use_q <= '0;
      nslots_q       <= '0;
      cnt_q          <= '0;
      vld_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL_BUDGET: total_q <= cfg_wdata_i;
          CFG_SLOTS_IN_USE: slots_in_use_q <= cfg_wdata_i[4:0];
          default: total_q <= total_q;
        endcase
      end
      if ((cmd_i.op == DOP_STORE_REC) && store_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.op == DOP_FINISH) begin
        cnt_q <= '0;
      end
      if (cmd_i.op == DOP_START) begin
        vld_q    <= '0;
        nslots_q <= (slots_in_use_q < 5'(SLOTS)) ? slots_in_use_q : 5'(SLOTS);
      end else if ((cmd_i.op == DOP_APPLY) && en_q && (cmd_i.kind != PK_SUM)) begin
        vld_q[p_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DOP_START: begin
        caps_q     <= '0;
        tfree_q    <= '0;
        req_def_q  <= '0;
        req_noex_q <= '0;
        req_ex_q   <= '0;
        n_def_q    <= 1'b0;
        n_noex_q   <= 1'b0;
        n_ex_q     <= 1'b0;
      end
      DOP_EVAL: begin
        en_q <= cond && hit;
        p_q  <= pos;
        t_q  <= t_d;
      end
      DOP_FREEP:    freep_q <= wsub(total_q, caps_q);
      DOP_DEF_OK:   freep_q <= freep_q - req_def_q;
      DOP_PEND_DEF: pend_q  <= req_def_q - freep_q;
      DOP_PEND_G: begin
        pend_q  <= wmin(tfree_q, cmd_i.wx ? req_ex_q : req_noex_q);
        pend2_q <= wmin(tfree_q, cmd_i.wx ? req_ex_q : req_noex_q);
      end
      DOP_APPLY: begin
        case (cmd_i.kind)
          PK_SUM: begin
            caps_q  <= caps_q + WATT_W'(rd_q.cap);
            tfree_q <= tfree_q + WATT_W'(rd_q.fr);
            if (rd_q.mode == MODE_DEFAULT) begin
              n_def_q   <= 1'b1;
              req_def_q <= req_def_q + WATT_W'(rd_q.rq);
            end else if (rd_q.mode == MODE_GREEDY) begin
              if (rd_q.ex == '0) begin
                n_noex_q   <= 1'b1;
                req_noex_q <= req_noex_q + WATT_W'(rd_q.rq);
              end else begin
                n_ex_q   <= 1'b1;
                req_ex_q <= req_ex_q + WATT_W'(rd_q.rq);
              end
            end
          end
          PK_TFR: begin
            if (en_q) begin
              tfree_q <= wsub(tfree_q, t_q);
              pend_q  <= pend_q - t_q;
            end
          end
          PK_TEX: begin
            if (en_q) begin
              pend_q <= pend_q - t_q;
            end
          end
          PK_GRANT: begin
            if (en_q) begin
              if (cmd_i.src_pend2) begin
                pend2_q <= pend2_q - t_q;
              end else begin
                freep_q <= freep_q - t_q;
              end
              if (cmd_i.wx) begin
                req_ex_q <= wsub(req_ex_q, t_q);
              end else begin
                req_noex_q <= wsub(req_noex_q, t_q);
              end
            end
          end
          default: begin
            caps_q <= caps_q;
          end
        endcase
      end
      default: begin
        caps_q <= caps_q;
      end
    endcase
  end

  always_comb begin
    stat_o.loop_go = 1'b1;
    case (cmd_i.kind) inside
      PK_TFR, PK_TEX: stat_o.loop_go = (pend_q != '0);
      PK_GRANT:       stat_o.loop_go = (src != '0);
      default:        stat_o.loop_go = 1'b1;
    endcase
    stat_o.freep_nz     = (freep_q != '0);
    stat_o.freep_ge_def = (freep_q >= req_def_q);
    stat_o.pend_nz      = (pend_q != '0);
    stat_o.tfree_nz     = (tfree_q != '0);
    stat_o.n_def        = n_def_q;
    stat_o.n_noex       = n_noex_q;
    stat_o.n_ex         = n_ex_q;
    stat_o.req_noex_nz  = (req_noex_q != '0);
    stat_o.req_ex_nz    = (req_ex_q != '0);
  end

  assign cnt_o    = cnt_q;
  assign nslots_o = nslots_q;

endmodule

// ----- hw/rtl/pbr_ctrl.sv -----
module pbr_ctrl
  import pbr_pkg::*;
#(
  parameter int MAX_NODES = 16,
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_tuser_i,
  input  logic          s_tlast_i,
  output logic          s_tready_o,
  input  logic          m_tready_i,
  output logic          m_tvalid_o,
  output logic          m_tlast_o,
  input  pbr_stat_t     stat_i,
  input  logic [CW-1:0] cnt_i,
  input  logic [4:0]    nslots_i,
  output pbr_cmd_t      cmd_o,
  output logic [CW-1:0] idx_o,
  output logic [4:0]    out_idx_o
);

`include "power_budget_reallocator_top_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_EV,
    S_AP,
    S_FREEP,
    S_DEF_CHK,
    S_DEF_TFR_CHK,
    S_DEF_TEX_CHK,
    S_G_CHK,
    S_G_MID,
    S_G_NEXT,
    S_FINISH,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    STEP_SUM,
    STEP_DEF,
    STEP_DEF_TFR,
    STEP_DEF_TEX,
    STEP_G_FREE,
    STEP_G_TFR,
    STEP_G_PEND
  } step_e;

  state_e        state_q;
  step_e         step_q;
  logic          g_q;
  logic [CW-1:0] idx_q;
  logic [4:0]    k_q;
  logic          valid_q;
  logic          last_q;

  logic pass_end;
  logic take;

  assign pass_end   = (idx_q == cnt_i) || !stat_i.loop_go;
  assign take       = !valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.op        = DOP_NONE;
    cmd_o.src_pend2 = (step_q == STEP_G_PEND);
    cmd_o.wx        = g_q;
    unique case (step_q) inside
      STEP_SUM:                  cmd_o.kind = PK_SUM;
      STEP_DEF:                  cmd_o.kind = PK_DEF;
      STEP_DEF_TFR, STEP_G_TFR:  cmd_o.kind = PK_TFR;
      STEP_DEF_TEX:              cmd_o.kind = PK_TEX;
      STEP_G_FREE, STEP_G_PEND:  cmd_o.kind = PK_GRANT;
      default:                   cmd_o.kind = PK_SUM;
    endcase
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.op = s_tuser_i ? DOP_STORE_REC : DOP_LOAD_SLOT;
        end
      end
      S_START:   cmd_o.op = DOP_START;
      S_RD:      cmd_o.op = pass_end ? DOP_NONE : DOP_READ;
      S_EV:      cmd_o.op = DOP_EVAL;
      S_AP:      cmd_o.op = DOP_APPLY;
      S_FREEP:   cmd_o.op = DOP_FREEP;
      S_DEF_CHK: cmd_o.op = stat_i.freep_ge_def ? DOP_DEF_OK : DOP_PEND_DEF;
      S_G_MID: begin
        if ((g_q ? stat_i.req_ex_nz : stat_i.req_noex_nz) && stat_i.tfree_nz) begin
          cmd_o.op = DOP_PEND_G;
        end
      end
      S_FINISH:  cmd_o.op = DOP_FINISH;
      S_OUT: begin
        if (take && (k_q < nslots_i)) begin
          cmd_o.op = DOP_OUT_LOAD;
        end
      end
      default:   cmd_o.op = DOP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= STEP_SUM;
      g_q     <= 1'b0;
      idx_q   <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_tvalid_i && s_tuser_i && s_tlast_i) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          step_q  <= STEP_SUM;
          idx_q   <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          if (!pass_end) begin
            state_q <= S_EV;
          end else begin
            idx_q <= '0;
            unique case (step_q)
              STEP_SUM:     state_q <= S_FREEP;
              STEP_DEF:     state_q <= S_DEF_CHK;
              STEP_DEF_TFR: state_q <= S_DEF_TEX_CHK;
              STEP_DEF_TEX: state_q <= S_FINISH;
              STEP_G_FREE:  state_q <= S_G_MID;
              STEP_G_TFR: begin
                step_q  <= STEP_G_PEND;
                state_q <= S_RD;
              end
              STEP_G_PEND: begin
                state_q <= (!g_q && !stat_i.tfree_nz) ? S_FINISH : S_G_NEXT;
              end
              default: state_q <= S_FINISH;
            endcase
          end
        end
        S_EV: state_q <= S_AP;
        S_AP: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_RD;
        end
        S_FREEP: begin
          g_q <= 1'b0;
          if (stat_i.n_def) begin
            step_q  <= STEP_DEF;
            state_q <= S_RD;
          end else begin
            state_q <= S_G_CHK;
          end
        end
        S_DEF_CHK: begin
          state_q <= stat_i.freep_ge_def ? S_G_CHK : S_DEF_TFR_CHK;
        end
        S_DEF_TFR_CHK: begin
          if (stat_i.tfree_nz) begin
            step_q  <= STEP_DEF_TFR;
            state_q <= S_RD;
          end else begin
            state_q <= S_DEF_TEX_CHK;
          end
        end
        S_DEF_TEX_CHK: begin
          if (stat_i.pend_nz) begin
            step_q  <= STEP_DEF_TEX;
            state_q <= S_RD;
          end else begin
            state_q <= S_G_CHK;
          end
        end
        S_G_CHK: begin
          if (!(g_q ? stat_i.n_ex : stat_i.n_noex)) begin
            state_q <= S_G_NEXT;
          end else if (stat_i.freep_nz) begin
            step_q  <= STEP_G_FREE;
            state_q <= S_RD;
          end else begin
            state_q <= S_G_MID;
          end
        end
        S_G_MID: begin
          if ((g_q ? stat_i.req_ex_nz : stat_i.req_noex_nz) && stat_i.tfree_nz) begin
            step_q  <= STEP_G_TFR;
            state_q <= S_RD;
          end else begin
            state_q <= S_G_NEXT;
          end
        end
        S_G_NEXT: begin
          if (!g_q) begin
            g_q     <= 1'b1;
            state_q <= S_G_CHK;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          k_q     <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (take) begin
            if (k_q < nslots_i) begin
              valid_q <= 1'b1;
              last_q  <= ((k_q + 5'd1) == nslots_i);
              k_q     <= k_q + 5'd1;
            end else begin
              valid_q <= 1'b0;
              last_q  <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign idx_o      = idx_q;
  assign out_idx_o  = k_q;
  assign m_tvalid_o = valid_q;
  assign m_tlast_o  = last_q;

  `PBR_ASSERT(a_valid_in_out, valid_q |-> state_q == S_OUT, "result shown outside output phase")
  `PBR_ASSERT(a_idx_bound, (state_q == S_EV || state_q == S_AP) |-> idx_q < cnt_i, "index past records")
  `PBR_ASSERT(a_last_ends, valid_q && last_q && m_tready_i |=> state_q == S_IDLE, "round not closed")

endmodule

// ----- tb/pbr_checker.sv -----
`timescale 1ns / 1ps
// Watches the request, result and register write ports, predicts the commands of each
// round and compares every accepted result with the oldest prediction.
module pbr_checker
  import pbr_pkg::*;
#(
  parameter bit ACT_RECORD = 1'b1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [39:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           errors_o,
  output int           pending_o,
  output int           checked_o
);

  localparam int SLOTS = 16;
  localparam logic [63:0] MASK40 = 64'hFF_FFFF_FFFF;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] id;
    logic [1:0]  cmd;
    logic [39:0] amount;
    logic        last;
  } command_t;

  command_t cmd_q[$];

  logic [39:0] budget;
  logic [4:0]  slots_cfg;
  int          nsl;
  logic [15:0] slot_id[SLOTS];
  logic [15:0] rec_id[SLOTS];
  u64_t        rec_cap[SLOTS], rec_rq[SLOTS], rec_fr[SLOTS], rec_ex[SLOTS];
  logic [1:0]  rec_mode[SLOTS];
  int          rec_cnt;
  u64_t        wrq[SLOTS], wfr[SLOTS], wex[SLOTS];
  logic [1:0]  slot_cmd[SLOTS];
  u64_t        slot_amt[SLOTS];

  function automatic u64_t sat_sub(u64_t a, u64_t b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic u64_t min64(u64_t a, u64_t b);
    return (a < b) ? a : b;
  endfunction

  // The first matching slot wins; an id held by no slot in use gives -1.
  function automatic int lookup(logic [15:0] id);
    for (int k = 0; k < nsl; k++) begin
      if (slot_id[k] == id) return k;
    end
    return -1;
  endfunction

  task automatic book(int p, logic [1:0] c, u64_t a);
    slot_cmd[p] = c;
    slot_amt[p] = (slot_amt[p] + a) & MASK40;
  endtask

  task automatic reclaim_freeable(inout u64_t pend, inout u64_t pool);
    int   p;
    u64_t t;
    for (int i = 0; pend != 0 && i < rec_cnt; i++) begin
      p = lookup(rec_id[i]);
      if (wfr[i] != 0 && p >= 0) begin
        t = min64(pend, wfr[i]);
        book(p, CMD_RED, t);
        pool = sat_sub(pool, t);
        pend = sat_sub(pend, t);
        wfr[i] -= t;
      end
    end
  endtask

  task automatic reclaim_extra(inout u64_t pend);
    int   p;
    u64_t t;
    for (int i = 0; pend != 0 && i < rec_cnt; i++) begin
      p = lookup(rec_id[i]);
      if (wex[i] != 0 && p >= 0) begin
        t = min64(pend, wex[i]);
        book(p, CMD_RED, t);
        pend = sat_sub(pend, t);
        wex[i] -= t;
      end
    end
  endtask

  task automatic grant_greedy(inout u64_t src, inout u64_t pend, input bit with_extra);
    int   p;
    u64_t t;
    for (int i = 0; i < rec_cnt && src != 0; i++) begin
      p = lookup(rec_id[i]);
      if (rec_mode[i] == MODE_GREEDY && ((wex[i] != 0) == with_extra) && p >= 0) begin
        t = min64(src, wrq[i]);
        book(p, CMD_INC, t);
        src = sat_sub(src, t);
        pend = sat_sub(pend, t);
        wrq[i] -= t;
      end
    end
  endtask

  task automatic reallocate();
    u64_t caps, tfree, req_def, req_noex, req_ex, freep, pend, pend2;
    int   n_def, n_noex, n_ex, p;
    caps = 0; tfree = 0; req_def = 0; req_noex = 0; req_ex = 0;
    n_def = 0; n_noex = 0; n_ex = 0;
    for (int i = 0; i < rec_cnt; i++) begin
      wrq[i] = rec_rq[i];
      wfr[i] = rec_fr[i];
      wex[i] = rec_ex[i];
      caps += rec_cap[i];
      tfree += rec_fr[i];
      if (rec_mode[i] == MODE_DEFAULT) begin
        n_def++;
        req_def += rec_rq[i];
      end else if (rec_mode[i] == MODE_GREEDY) begin
        if (rec_ex[i] == 0) begin
          n_noex++;
          req_noex += rec_rq[i];
        end else begin
          n_ex++;
          req_ex += rec_rq[i];
        end
      end
    end
    freep = sat_sub({24'd0, budget}, caps);

    if (n_def != 0) begin
      for (int i = 0; i < rec_cnt; i++) begin
        p = lookup(rec_id[i]);
        if (rec_mode[i] == MODE_DEFAULT && p >= 0) book(p, CMD_INC, wrq[i]);
      end
      if (freep >= req_def) begin
        freep -= req_def;
      end else begin
        pend = req_def - freep;
        if (tfree != 0) reclaim_freeable(pend, tfree);
        if (pend != 0) begin
          // Freeable power fell short: extra power is reclaimed and the round then stops.
          reclaim_extra(pend);
          return;
        end
      end
    end

    if (n_noex != 0) begin
      if (freep != 0) grant_greedy(freep, req_noex, 1'b0);
      if (req_noex != 0 && tfree != 0) begin
        pend = min64(tfree, req_noex);
        pend2 = pend;
        reclaim_freeable(pend, tfree);
        grant_greedy(pend2, req_noex, 1'b0);
        if (tfree == 0) return;
      end
    end

    if (n_ex != 0) begin
      if (freep != 0) grant_greedy(freep, req_ex, 1'b1);
      if (req_ex != 0 && tfree != 0) begin
        pend = min64(tfree, req_ex);
        pend2 = pend;
        reclaim_freeable(pend, tfree);
        grant_greedy(pend2, req_ex, 1'b1);
      end
    end
  endtask

  task automatic close_round();
    command_t c;
    nsl = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
    for (int k = 0; k < SLOTS; k++) begin
      slot_cmd[k] = CMD_NONE;
      slot_amt[k] = 0;
    end
    reallocate();
    rec_cnt = 0;
    for (int k = 0; k < nsl; k++) begin
      c.slot = k[3:0];
      c.id = slot_id[k];
      c.cmd = slot_cmd[k];
      c.amount = slot_amt[k][39:0];
      c.last = (k + 1 == nsl);
      cmd_q.push_back(c);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    command_t exp_c, got;
    if (!rst_ni) begin
      budget = '0;
      slots_cfg = '0;
      rec_cnt = 0;
      errors_o = 0;
      checked_o = 0;
      cmd_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TOTAL_BUDGET) budget = cfg_wdata_i;
        else slots_cfg = cfg_wdata_i[4:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser != ACT_RECORD) begin
          slot_id[s_axis_tdata[3:0]] = s_axis_tdata[19:4];
        end else begin
          if (rec_cnt < SLOTS) begin
            rec_id[rec_cnt]   = s_axis_tdata[19:4];
            rec_cap[rec_cnt]  = {32'd0, s_axis_tdata[51:20]};
            rec_rq[rec_cnt]   = {32'd0, s_axis_tdata[83:52]};
            rec_fr[rec_cnt]   = {32'd0, s_axis_tdata[115:84]};
            rec_ex[rec_cnt]   = {32'd0, s_axis_tdata[147:116]};
            rec_mode[rec_cnt] = s_axis_tdata[149:148];
            rec_cnt++;
          end
          if (s_axis_tlast) close_round();
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.slot = m_axis_tdata[3:0];
        got.id = m_axis_tdata[19:4];
        got.cmd = m_axis_tdata[21:20];
        got.amount = m_axis_tdata[61:22];
        got.last = m_axis_tlast;
        checked_o++;
        if (cmd_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected command slot=%0d id=%h cmd=%0d amount=%0d last=%0b",
                   $time, got.slot, got.id, got.cmd, got.amount, got.last);
        end else begin
          exp_c = cmd_q.pop_front();
          if (got !== exp_c) begin
            errors_o++;
            $display("%0t: mismatch expected slot=%0d id=%h cmd=%0d amount=%0d last=%0b",
                     $time, exp_c.slot, exp_c.id, exp_c.cmd, exp_c.amount, exp_c.last);
            $display("%0t:          actual   slot=%0d id=%h cmd=%0d amount=%0d last=%0b",
                     $time, got.slot, got.id, got.cmd, got.amount, got.last);
          end
        end
      end
    end
    pending_o = cmd_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import pbr_pkg::*;

  localparam bit ACT_LOAD   = 1'b0;
  localparam bit ACT_RECORD = 1'b1;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [39:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  int errors, pending, checked;
  int burst_left = 0;
  int rounds = 0;
  int requests = 0;
  int stall_cnt = 0;
  logic [15:0] ids[16];

  always #10 clk_i = ~clk_i;

  power_budget_reallocator_top DUT (.*);

  pbr_checker #(.ACT_RECORD(ACT_RECORD)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // The receiver cycles through phases: always ready, random, sparse and mostly ready.
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_cnt[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= (stall_cnt[2:0] == 3'd0);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send(bit act, logic [3:0] slot, logic [15:0] id, logic [31:0] cap,
                      logic [31:0] rq, logic [31:0] fr, logic [31:0] ex,
                      logic [1:0] mode, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tdata <= {2'b00, mode, ex, fr, rq, cap, id, slot};
    s_axis_tuser <= act;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    requests++;
  endtask

  task automatic load_slot(logic [3:0] slot, logic [15:0] id);
    ids[slot] = id;
    send(ACT_LOAD, slot, id, $urandom, $urandom, $urandom, $urandom,
         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [31:0] watts();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  // One status record per sub-manager; most ids match a slot, a few are unknown.
  task automatic random_round(int nrec);
    logic [15:0] id;
    for (int i = 0; i < nrec; i++) begin
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ids[$urandom_range(0, 15)];
      send(ACT_RECORD, 4'($urandom), id, watts(), watts(), watts(),
           ($urandom_range(0, 2) == 0) ? 32'd0 : watts(), 2'($urandom_range(0, 3)),
           i == nrec - 1);
    end
    rounds++;
  endtask

  // Waits out every expected command and any round that emits none.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [39:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(CFG_TOTAL_BUDGET, 40'd1000);
    write_reg(CFG_SLOTS_IN_USE, 40'd16);
    for (int s = 0; s < 16; s++) load_slot(s[3:0], (s == 15) ? 16'hFFFF : 16'(s * 16'h1111));
    // Default requesters short of budget, covered first from freeable and then extra power.
    send(ACT_RECORD, 4'hF, ids[1], 32'd600, 32'd900, 32'd100, 32'd0, MODE_DEFAULT, 1'b0);
    send(ACT_RECORD, 4'h0, ids[2], 32'd300, 32'd0, 32'd50, 32'd500, MODE_OTHER, 1'b0);
    send(ACT_RECORD, 4'h0, 16'h1234, 32'd0, 32'd10, 32'd10, 32'd10, MODE_DEFAULT, 1'b0);
    send(ACT_RECORD, 4'h0, ids[1], 32'd0, 32'd5, 32'd0, 32'd0, MODE_GREEDY, 1'b1);
    rounds++;
    // Greedy nodes with and without extra power, then a round with extreme values.
    send(ACT_RECORD, 4'h0, ids[3], 32'd100, 32'd400, 32'd0, 32'd0, MODE_GREEDY, 1'b0);
    send(ACT_RECORD, 4'h0, ids[4], 32'd100, 32'd400, 32'd0, 32'd7, MODE_GREEDY, 1'b0);
    send(ACT_RECORD, 4'h0, ids[5], 32'd100, 32'd0, 32'd300, 32'd0, MODE_RESERVED, 1'b1);
    rounds++;
    send(ACT_RECORD, 4'h0, ids[15], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, MODE_GREEDY, 1'b1);
    rounds++;
    drain();
    write_reg(CFG_TOTAL_BUDGET, 40'hFF_FFFF_FFFF);
    write_reg(CFG_SLOTS_IN_USE, 40'd31);
    random_round(18);
    drain();
    write_reg(CFG_SLOTS_IN_USE, 40'd0);
    random_round(3);
    drain();

    while (requests < 150) begin
      write_reg(CFG_TOTAL_BUDGET, ($urandom_range(0, 3) == 0) ? 40'd0 :
                {8'($urandom), 32'($urandom)} >> $urandom_range(0, 30));
      write_reg(CFG_SLOTS_IN_USE,
                ($urandom_range(0, 4) == 0) ? 40'd1 : 40'($urandom_range(2, 17)));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) load_slot(4'($urandom), 16'($urandom));
        random_round($urandom_range(1, 8));
      end
      drain();
    end

    $display("Ran %0d requests in %0d rounds; %0d commands checked.", requests, rounds,
             checked);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #8ms;
    $display("Timeout with %0d commands still expected.", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
